// File: sv/ptrg_pkg.sv
// Package for the polyline tube ring generator.
// Holds sequencer states, fixed arithmetic widths and the triangle corner table.
// No dependencies.
package ptrg_pkg;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_SCALE  = 10'b00_0000_0010,
        S_HELP   = 10'b00_0000_0100,
        S_CROSS  = 10'b00_0000_1000,
        S_NSHIFT = 10'b00_0001_0000,
        S_SQ     = 10'b00_0010_0000,
        S_SQRT   = 10'b00_0100_0000,
        S_DIV    = 10'b00_1000_0000,
        S_OFF    = 10'b01_0000_0000,
        S_EMIT   = 10'b10_0000_0000
    } t_state;

    localparam int FRAC     = 30;   // unit vectors are Q2.30
    localparam int A_W      = 31;   // scaled direction component
    localparam int U_W      = 32;   // unit vector component
    localparam int MUL_W    = 32;   // shared multiplier operand
    localparam int PROD_W   = 64;   // shared multiplier product
    localparam int CR_W     = 62;   // cross product component
    localparam int MAG_W    = 61;   // magnitude under normalization
    localparam int SQ_W     = 63;   // sum of squares and root work registers
    localparam int ROOT_W   = 31;   // final root and divider width
    localparam int OFF_W    = 32;   // ring offset, Q16.16
    localparam int RADIUS_W = 31;

    localparam int SQRT_STEPS = 31;
    localparam int DIV_STEPS  = 31;
    localparam int CROSS_LAST = 6;
    localparam int SQ_LAST    = 3;
    localparam int OFF_LAST   = 6;
    localparam int EMIT_RING  = 4;
    localparam int EMIT_ALL   = 12;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 31'd262144;   // 4.0

    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_TRI    = 1'b1;

    typedef logic signed [U_W-1:0]   t_unit;
    typedef logic signed [OFF_W-1:0] t_off;

    // Corner code of a triangle slot: bit 2 set selects the current ring,
    // bits 1:0 give the corner.
    function automatic logic [2:0] tri_corner(input logic [2:0] tri_sel,
                                              input logic [1:0] slot);
        logic [8:0] row;
        unique case (tri_sel)
            3'd0:    row = {3'b000, 3'b100, 3'b001};
            3'd1:    row = {3'b001, 3'b100, 3'b101};
            3'd2:    row = {3'b101, 3'b110, 3'b001};
            3'd3:    row = {3'b001, 3'b110, 3'b010};
            3'd4:    row = {3'b010, 3'b110, 3'b011};
            3'd5:    row = {3'b011, 3'b110, 3'b111};
            3'd6:    row = {3'b111, 3'b100, 3'b011};
            default: row = {3'b011, 3'b100, 3'b000};
        endcase
        unique case (slot)
            2'd0:    tri_corner = row[8:6];
            2'd1:    tri_corner = row[5:3];
            2'd2:    tri_corner = row[2:0];
            default: tri_corner = 3'b000;
        endcase
    endfunction

endpackage

// File: sv/ptrg_point_if.sv
// Input point channel of the tube ring generator.
// Valid/ready handshake with one signed point per transaction; no dependencies.
interface ptrg_point_if #(parameter int COORD_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;

    modport source(output valid, output point_x, output point_y, output point_z,
                   input ready);
    modport sink(input valid, input point_x, input point_y, input point_z,
                 output ready);
endinterface

// File: sv/ptrg_item_if.sv
// Result channel of the tube ring generator: ring vertices and triangles.
// Valid/ready handshake, one result per transaction; no dependencies.
interface ptrg_item_if #(parameter int COORD_WIDTH = 32, parameter int INDEX_WIDTH = 16);
    logic                          valid;
    logic                          ready;
    logic                          item_kind;
    logic signed [COORD_WIDTH-1:0] vertex_x;
    logic signed [COORD_WIDTH-1:0] vertex_y;
    logic signed [COORD_WIDTH-1:0] vertex_z;
    logic [INDEX_WIDTH-1:0]        vertex_index;
    logic [INDEX_WIDTH-1:0]        tri_first;
    logic [INDEX_WIDTH-1:0]        tri_second;
    logic [INDEX_WIDTH-1:0]        tri_third;
    logic                          degenerate;
    logic                          last_of_run;

    modport source(output valid, output item_kind, output vertex_x, output vertex_y,
                   output vertex_z, output vertex_index, output tri_first,
                   output tri_second, output tri_third, output degenerate,
                   output last_of_run, input ready);
    modport sink(input valid, input item_kind, input vertex_x, input vertex_y,
                 input vertex_z, input vertex_index, input tri_first, input tri_second,
                 input tri_third, input degenerate, input last_of_run, output ready);
endinterface

// File: sv/polyline_tube_ring_generator_core.sv
// Top level of the polyline tube ring generator.
// Depends on ptrg_pkg, ptrg_point_if and ptrg_item_if.
//
// Takes polyline points (signed Q16.16) one transaction at a time. The first point
// is only stored. Each later point forms the direction from the previous point,
// picks a helper vector, builds u = norm(d x b) and v = norm(d x u) and emits four
// ring vertices around the previous point (+u, -u, +v, -v times tube_radius),
// followed by eight joining triangles once a ring exists. All arithmetic runs on
// one shared 32x32 multiplier, a one-bit-per-cycle square root and a
// one-bit-per-cycle restoring divider under a small sequencer; the block takes no
// new point until the current one is finished. The work per point grows with the
// normalizing shifts of each cross product and the scaling shifts of the
// direction, plus the result transactions; the three divisions of each
// normalization dominate. The result register lets the last result of a point
// wait while the next point is taken.
module polyline_tube_ring_generator_core #(
    parameter int COORD_WIDTH = 32,
    parameter int INDEX_WIDTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ptrg_pkg::RADIUS_W-1:0]   i_cfg_wdata,
    ptrg_point_if.sink                      i_point,
    ptrg_item_if.source                     o_item
);
    import ptrg_pkg::*;

    localparam int CW     = COORD_WIDTH;
    localparam int D_W    = CW + 1;
    localparam int RING_W = INDEX_WIDTH - 2;
    localparam int SUM_W  = ((CW > OFF_W) ? CW : OFF_W) + 1;
    localparam logic signed [SUM_W-1:0] SAT_HI = {{(SUM_W-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO = {{(SUM_W-CW+1){1'b1}}, {(CW-1){1'b0}}};
    localparam logic [SQ_W-1:0] SQRT_TOP = SQ_W'(1) << (2 * (SQRT_STEPS - 1));

    // Sequencer and persistent state
    t_state                 r_state;
    logic [RADIUS_W-1:0]    r_radius;
    logic                   r_have_prev;
    logic                   r_started;
    logic [RING_W-1:0]      r_ring;
    logic signed [CW-1:0]   r_prev [3];
    logic signed [CW-1:0]   r_cur  [3];

    // Working registers of one point
    logic signed [D_W-1:0]  r_d    [3];
    logic [MAG_W-1:0]       r_mag  [3];
    logic                   r_neg  [3];
    logic signed [A_W-1:0]  r_a    [3];
    logic signed [A_W-1:0]  r_b    [3];
    logic signed [CR_W-1:0] r_cr   [3];
    t_unit                  r_u    [3];
    t_unit                  r_v    [3];
    t_off                   r_offu [3];
    t_off                   r_offv [3];
    logic                   r_deg;
    logic                   r_pass;
    logic [5:0]             r_cnt;
    logic [1:0]             r_comp;
    logic [SQ_W-1:0]        r_s;
    logic [SQ_W-1:0]        r_root;
    logic [SQ_W-1:0]        r_bit;
    logic [ROOT_W-1:0]      r_rem;
    logic [ROOT_W-1:0]      r_dvd;
    logic [ROOT_W-1:0]      r_q;
    logic signed [PROD_W-1:0] r_prod;
    logic                   r_prod_neg;

    // Result register
    logic                   r_o_valid;
    logic                   r_o_kind;
    logic signed [CW-1:0]   r_o_xyz [3];
    logic [INDEX_WIDTH-1:0] r_o_vidx;
    logic [INDEX_WIDTH-1:0] r_o_tri [3];
    logic                   r_o_deg;
    logic                   r_o_last;

    // Combinational helpers
    logic signed [CW-1:0]     w_in    [3];
    logic [D_W-1:0]           w_dmag  [3];
    logic [MAG_W-1:0]         w_crmag [3];
    logic signed [A_W-1:0]    w_a     [3];
    logic signed [A_W-1:0]    w_b     [3];
    logic                     w_any_hi, w_all_lo, w_all_zero;
    logic [1:0]               w_xi, w_yi;
    logic signed [MUL_W-1:0]  w_ma, w_mb;
    logic                     w_mneg;
    t_unit                    w_unit_sel;
    logic [1:0]               w_acc_comp;
    logic [SQ_W-1:0]          w_sq_t;
    logic                     w_sq_ge;
    logic [ROOT_W:0]          w_dcmp;
    logic                     w_dge;
    logic [ROOT_W:0]          w_dsub;
    t_unit                    w_unit;
    t_off                     w_off;
    logic [2:0]               w_off_j;
    logic signed [CW-1:0]     w_vx    [3];
    logic [2:0]               w_tsel;
    logic [RING_W-1:0]        w_ring_prev;
    logic [INDEX_WIDTH-1:0]   w_tidx  [3];
    logic                     w_is_vtx;
    logic                     w_last;
    logic                     w_out_free;

    function automatic logic signed [CW-1:0] sat_coord(input logic signed [SUM_W-1:0] s);
        if (s > SAT_HI) begin
            sat_coord = {1'b0, {(CW-1){1'b1}}};
        end else if (s < SAT_LO) begin
            sat_coord = {1'b1, {(CW-1){1'b0}}};
        end else begin
            sat_coord = s[CW-1:0];
        end
    endfunction

    assign w_in[0] = i_point.point_x;
    assign w_in[1] = i_point.point_y;
    assign w_in[2] = i_point.point_z;

    assign i_point.ready = (r_state == S_IDLE);
    assign w_out_free    = !r_o_valid || o_item.ready;

    // Magnitudes, range checks and the helper vector choice
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_dmag[i]  = r_d[i][D_W-1] ? D_W'(-r_d[i]) : D_W'(r_d[i]);
            w_crmag[i] = r_cr[i][CR_W-1] ? MAG_W'(-r_cr[i]) : MAG_W'(r_cr[i]);
            w_a[i]     = r_d[i][D_W-1] ? -$signed({1'b0, r_mag[i][FRAC-1:0]})
                                       :  $signed({1'b0, r_mag[i][FRAC-1:0]});
        end
        w_any_hi   = (|r_mag[0][MAG_W-1:FRAC]) || (|r_mag[1][MAG_W-1:FRAC])
                  || (|r_mag[2][MAG_W-1:FRAC]);
        w_all_lo   = !((|r_mag[0][MAG_W-1:FRAC-1]) || (|r_mag[1][MAG_W-1:FRAC-1])
                  || (|r_mag[2][MAG_W-1:FRAC-1]));
        w_all_zero = !((|r_mag[0]) || (|r_mag[1]) || (|r_mag[2]));

        // Helper choice compares the unscaled direction
        if (r_d[0] >= r_d[1]) begin
            if (r_d[1] >= r_d[2]) begin
                w_b[0] = w_a[1]; w_b[1] = -w_a[0]; w_b[2] = w_a[2];
            end else begin
                w_b[0] = w_a[2]; w_b[1] = w_a[1];  w_b[2] = -w_a[0];
            end
        end else begin
            if (r_d[0] >= r_d[2]) begin
                w_b[0] = w_a[1]; w_b[1] = -w_a[0]; w_b[2] = w_a[2];
            end else begin
                w_b[0] = w_a[0]; w_b[1] = w_a[2];  w_b[2] = -w_a[1];
            end
        end
    end

    // Shared multiplier operand selection
    always_comb begin
        w_xi   = 2'd0;
        w_yi   = 2'd0;
        w_ma   = '0;
        w_mb   = '0;
        w_mneg = 1'b0;
        unique case (r_state)
            S_CROSS: begin
                unique case (r_cnt[2:0])
                    3'd0:    begin w_xi = 2'd1; w_yi = 2'd2; end
                    3'd1:    begin w_xi = 2'd2; w_yi = 2'd1; end
                    3'd2:    begin w_xi = 2'd2; w_yi = 2'd0; end
                    3'd3:    begin w_xi = 2'd0; w_yi = 2'd2; end
                    3'd4:    begin w_xi = 2'd0; w_yi = 2'd1; end
                    default: begin w_xi = 2'd1; w_yi = 2'd0; end
                endcase
            end
            S_SQ:    w_yi = (r_cnt[1:0] == 2'd3) ? 2'd0 : r_cnt[1:0];
            S_OFF:   w_yi = (r_cnt < 6'd3) ? r_cnt[1:0]
                          : ((r_cnt < 6'd6) ? 2'(r_cnt - 6'd3) : 2'd0);
            S_DIV:   w_yi = r_comp;
            default: w_yi = 2'd0;
        endcase

        w_unit_sel = (r_cnt >= 6'd3) ? r_v[w_yi] : r_u[w_yi];

        unique case (r_state)
            S_CROSS: begin
                w_ma = MUL_W'(r_a[w_xi]);
                w_mb = r_pass ? r_u[w_yi] : MUL_W'(r_b[w_yi]);
            end
            S_SQ: begin
                w_ma = $signed({2'b00, r_mag[w_yi][FRAC-1:0]});
                w_mb = $signed({2'b00, r_mag[w_yi][FRAC-1:0]});
            end
            S_OFF: begin
                w_mneg = w_unit_sel[U_W-1];
                w_ma   = w_unit_sel[U_W-1] ? -w_unit_sel : w_unit_sel;
                w_mb   = $signed({1'b0, r_radius});
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    // Square-root and divider steps, accumulate and offset helpers
    always_comb begin
        w_acc_comp = (r_cnt <= 6'd2) ? 2'd0 : ((r_cnt <= 6'd4) ? 2'd1 : 2'd2);
        w_sq_t     = r_root + r_bit;
        w_sq_ge    = (r_s >= w_sq_t);
        w_dcmp     = {r_rem, r_dvd[ROOT_W-1]};
        w_dge      = (w_dcmp >= {1'b0, r_root[ROOT_W-1:0]});
        w_dsub     = w_dcmp - {1'b0, r_root[ROOT_W-1:0]};
        w_unit     = r_neg[r_comp] ? -U_W'(r_q) : U_W'(r_q);
        w_off      = r_prod_neg ? -OFF_W'(r_prod[FRAC+OFF_W-1:FRAC])
                                :  OFF_W'(r_prod[FRAC+OFF_W-1:FRAC]);
        w_off_j    = 3'(r_cnt - 6'd1);
    end

    // Result payload for the current emit slot
    always_comb begin
        w_is_vtx    = (r_cnt < 6'(EMIT_RING));
        w_last      = r_started ? (r_cnt == 6'(EMIT_ALL - 1)) : (r_cnt == 6'(EMIT_RING - 1));
        w_tsel      = 3'(r_cnt - 6'(EMIT_RING));
        w_ring_prev = r_ring - RING_W'(1);
        for (int i = 0; i < 3; i++) begin
            logic signed [OFF_W-1:0] o;
            logic signed [OFF_W-1:0] os;
            logic [2:0]              code;
            o         = r_cnt[1] ? r_offv[i] : r_offu[i];
            os        = r_cnt[0] ? -o : o;
            w_vx[i]   = sat_coord(SUM_W'(r_prev[i]) + SUM_W'(os));
            code      = tri_corner(w_tsel, 2'(i));
            w_tidx[i] = {code[2] ? r_ring : w_ring_prev, code[1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod     <= PROD_W'(w_ma) * PROD_W'(w_mb);
        r_prod_neg <= w_mneg;

        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_radius    <= RADIUS_RESET;
            r_have_prev <= 1'b0;
            r_started   <= 1'b0;
            r_ring      <= '0;
            r_o_valid   <= 1'b0;
            r_cnt       <= '0;
            r_comp      <= '0;
            r_pass      <= 1'b0;
            r_deg       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_radius <= i_cfg_wdata;
            end
            if (r_o_valid && o_item.ready) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_point.valid) begin
                        for (int i = 0; i < 3; i++) r_cur[i] <= w_in[i];
                        if (!r_have_prev) begin
                            // First point: store it, no results
                            for (int i = 0; i < 3; i++) r_prev[i] <= w_in[i];
                            r_have_prev <= 1'b1;
                        end else begin
                            for (int i = 0; i < 3; i++) begin
                                r_d[i] <= D_W'(w_in[i]) - D_W'(r_prev[i]);
                            end
                            r_deg   <= 1'b0;
                            r_pass  <= 1'b0;
                            r_cnt   <= '0;
                            r_state <= S_SCALE;
                        end
                    end
                end

                S_SCALE: begin
                    // Shift the direction down until every component is below 2^30
                    if (r_cnt == 6'd0) begin
                        for (int i = 0; i < 3; i++) r_mag[i] <= MAG_W'(w_dmag[i]);
                        r_cnt <= 6'd1;
                    end else if (w_any_hi) begin
                        for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] >> 1;
                    end else begin
                        r_state <= S_HELP;
                    end
                end

                S_HELP: begin
                    for (int i = 0; i < 3; i++) begin
                        r_a[i] <= w_a[i];
                        r_b[i] <= w_b[i];
                    end
                    r_cnt   <= '0;
                    r_state <= S_CROSS;
                end

                S_CROSS: begin
                    // Issue six products, accumulate each in the cycle after it is issued
                    if (r_cnt == 6'd0) begin
                        for (int i = 0; i < 3; i++) r_cr[i] <= '0;
                    end else if (r_cnt[0]) begin
                        r_cr[w_acc_comp] <= r_cr[w_acc_comp] + CR_W'(r_prod);
                    end else begin
                        r_cr[w_acc_comp] <= r_cr[w_acc_comp] - CR_W'(r_prod);
                    end
                    if (r_cnt == 6'(CROSS_LAST)) begin
                        r_cnt   <= '0;
                        r_state <= S_NSHIFT;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end

                S_NSHIFT: begin
                    // Bring the largest magnitude into [2^29, 2^30)
                    if (r_cnt == 6'd0) begin
                        for (int i = 0; i < 3; i++) begin
                            r_mag[i] <= w_crmag[i];
                            r_neg[i] <= r_cr[i][CR_W-1];
                        end
                        r_cnt <= 6'd1;
                    end else if (w_all_zero) begin
                        // Zero-length cross product: zero unit vector, flag it
                        r_deg <= 1'b1;
                        r_cnt <= '0;
                        if (!r_pass) begin
                            for (int i = 0; i < 3; i++) r_u[i] <= '0;
                            r_pass  <= 1'b1;
                            r_state <= S_CROSS;
                        end else begin
                            for (int i = 0; i < 3; i++) r_v[i] <= '0;
                            r_state <= S_OFF;
                        end
                    end else if (w_any_hi) begin
                        for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] >> 1;
                    end else if (w_all_lo) begin
                        for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] << 1;
                    end else begin
                        r_cnt   <= '0;
                        r_state <= S_SQ;
                    end
                end

                S_SQ: begin
                    if (r_cnt == 6'd0) begin
                        r_s <= '0;
                    end else begin
                        r_s <= r_s + SQ_W'(r_prod);
                    end
                    if (r_cnt == 6'(SQ_LAST)) begin
                        r_root  <= '0;
                        r_bit   <= SQRT_TOP;
                        r_cnt   <= '0;
                        r_state <= S_SQRT;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end

                S_SQRT: begin
                    // One result bit per cycle
                    if (w_sq_ge) begin
                        r_s    <= r_s - w_sq_t;
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_cnt == 6'(SQRT_STEPS - 1)) begin
                        r_cnt   <= '0;
                        r_comp  <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end

                S_DIV: begin
                    // Restoring division of mag * 2^30 by the root, one bit a cycle
                    if (r_cnt == 6'd0) begin
                        r_rem <= ROOT_W'(r_mag[w_yi][FRAC-1:1]);
                        r_dvd <= {r_mag[w_yi][0], {(ROOT_W-1){1'b0}}};
                        r_q   <= '0;
                        r_cnt <= 6'd1;
                    end else if (r_cnt <= 6'(DIV_STEPS)) begin
                        r_rem <= w_dge ? w_dsub[ROOT_W-1:0] : w_dcmp[ROOT_W-1:0];
                        r_q   <= {r_q[ROOT_W-2:0], w_dge};
                        r_dvd <= r_dvd << 1;
                        r_cnt <= r_cnt + 6'd1;
                    end else begin
                        if (!r_pass) begin
                            r_u[r_comp] <= w_unit;
                        end else begin
                            r_v[r_comp] <= w_unit;
                        end
                        r_cnt <= '0;
                        if (r_comp == 2'd2) begin
                            r_comp <= '0;
                            if (!r_pass) begin
                                r_pass  <= 1'b1;
                                r_state <= S_CROSS;
                            end else begin
                                r_state <= S_OFF;
                            end
                        end else begin
                            r_comp <= r_comp + 2'd1;
                        end
                    end
                end

                S_OFF: begin
                    // Scale u then v by the radius, one product per cycle
                    if (r_cnt != 6'd0) begin
                        if (w_off_j < 3'd3) begin
                            r_offu[w_off_j[1:0]] <= w_off;
                        end else begin
                            r_offv[2'(w_off_j - 3'd3)] <= w_off;
                        end
                    end
                    if (r_cnt == 6'(OFF_LAST)) begin
                        r_cnt   <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end

                S_EMIT: begin
                    // Advance one result whenever the result register is free
                    if (w_out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_kind  <= w_is_vtx ? KIND_VERTEX : KIND_TRI;
                        for (int i = 0; i < 3; i++) begin
                            r_o_xyz[i] <= w_is_vtx ? w_vx[i] : '0;
                            r_o_tri[i] <= w_is_vtx ? '0 : w_tidx[i];
                        end
                        r_o_vidx <= w_is_vtx ? {r_ring, r_cnt[1:0]} : '0;
                        r_o_deg  <= w_is_vtx && r_deg;
                        r_o_last <= w_last;
                        if (w_last) begin
                            for (int i = 0; i < 3; i++) r_prev[i] <= r_cur[i];
                            r_ring    <= r_ring + RING_W'(1);
                            r_started <= 1'b1;
                            r_cnt     <= '0;
                            r_state   <= S_IDLE;
                        end else begin
                            r_cnt <= r_cnt + 6'd1;
                        end
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_item.valid        = r_o_valid;
    assign o_item.item_kind    = r_o_kind;
    assign o_item.vertex_x     = r_o_xyz[0];
    assign o_item.vertex_y     = r_o_xyz[1];
    assign o_item.vertex_z     = r_o_xyz[2];
    assign o_item.vertex_index = r_o_vidx;
    assign o_item.tri_first    = r_o_tri[0];
    assign o_item.tri_second   = r_o_tri[1];
    assign o_item.tri_third    = r_o_tri[2];
    assign o_item.degenerate   = r_o_deg;
    assign o_item.last_of_run  = r_o_last;

    // A new result only appears out of the emit phase
    a_rise_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_state == S_EMIT))
        else $error("result appeared outside the emit phase");

    // A nonzero vector normalizes to a root in [2^29, 2^31)
    a_root_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> ((r_root[ROOT_W-1:ROOT_W-2] != 2'b00)
                                && (r_root[SQ_W-1:ROOT_W] == '0)))
        else $error("divisor out of normalized range");

    // The first ring has no triangles
    a_first_ring_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && !r_started) |-> (r_cnt < 6'(EMIT_RING)))
        else $error("triangles emitted before a ring exists");

    // Work on a point only with a stored previous point
    a_busy_has_prev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> r_have_prev)
        else $error("sequencer busy without a previous point");

endmodule
